// ===== rtl/core/erc_pkg.sv =====
// ---------------------------------------------------------------------------
// erc_pkg
// Shared types and constants of the expiring receive-time cache.
// ---------------------------------------------------------------------------
`default_nettype none

package erc_pkg;

  // operation codes
  localparam logic [1:0] OP_STORE  = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  localparam int          RESULT_LIMIT = 16;
  localparam int          LIMIT_W      = $clog2(RESULT_LIMIT + 1);
  localparam int          QUEUE_DEPTH  = 2;
  localparam logic [15:0] VALIDITY_RESET = 16'd30;
  localparam logic [31:0] EXPIRY_MAX     = 32'hFFFF_FFFF;

  // APB register map
  localparam int   APB_AW       = 3;
  localparam logic REG_VALIDITY = 1'b0;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        now_ms;
    logic [7:0]         peer_id;
    logic signed [63:0] rx_stamp;
    logic [7:0]         seq_number;
  } erc_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL,
    ST_WRITE
  } erc_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/erc_channels_if.sv =====
// ---------------------------------------------------------------------------
// erc channel interfaces
// Valid/ready channels for request words and result words.
// ---------------------------------------------------------------------------
`default_nettype none

interface erc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [31:0]        now_ms;
  logic [7:0]         peer_id;
  logic signed [63:0] rx_stamp;
  logic [7:0]         seq_number;

  modport source (output valid, operation, now_ms, peer_id, rx_stamp, seq_number,
                  input ready);
  modport sink   (input valid, operation, now_ms, peer_id, rx_stamp, seq_number,
                  output ready);
endinterface

interface erc_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic [7:0]         out_peer_id;
  logic signed [63:0] out_rx_stamp;
  logic [7:0]         out_seq_number;
  logic               last;

  modport source (output valid, found, out_peer_id, out_rx_stamp, out_seq_number, last,
                  input ready);
  modport sink   (input valid, found, out_peer_id, out_rx_stamp, out_seq_number, last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/expiring_rx_time_cache_unit.sv =====
// ---------------------------------------------------------------------------
// expiring_rx_time_cache_unit
// Peer table with expiry: store, lookup by id, and list of live entries.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake        | words
//  ---------+-----+------------------+-------------------------------------
//  in_ch    | in  | valid/ready      | one request (store, lookup, list)
//  out_ch   | out | valid/ready      | results; last marks the final one
//  apb      | in  | psel/penable     | validity period register at 0x0
//
//  Each request passes through the back end in steps: dispatch, a scan of one
//  table entry at a time over the single table read port, then a write or
//  report step. A store or lookup that hits ends its scan at the matching
//  entry. A two-word queue lets requests enter while a scan runs. List
//  results wait on out_ch.ready one word at a time.
//  Reset (rst, synchronous) clears the table and sets the period to 30 ms.
// ---------------------------------------------------------------------------
`default_nettype none

module expiring_rx_time_cache_unit #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  erc_in_if.sink                     in_ch,
  erc_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [erc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import erc_pkg::*;

  logic [15:0] validity_period_ms;
  erc_item_t   head;
  logic        head_valid;
  logic        pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VALIDITY) ? {16'd0, validity_period_ms} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      validity_period_ms <= VALIDITY_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_VALIDITY) begin
      validity_period_ms <= pwdata[15:0];
    end
  end

  erc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  erc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .head               (head),
    .head_valid         (head_valid),
    .pop                (pop),
    .validity_period_ms (validity_period_ms),
    .out_ch             (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/core/erc_front.sv =====
// ---------------------------------------------------------------------------
// erc_front
// Accepts request words, drops the unused opcode, and queues the rest.
// ---------------------------------------------------------------------------
`default_nettype none

module erc_front (
  input  logic               clk,
  input  logic               rst,
  erc_in_if.sink             in_ch,
  output erc_pkg::erc_item_t head,
  output logic               head_valid,
  input  logic               pop
);
  import erc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  erc_item_t     q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;
  logic          accept;
  logic          push;
  logic          known_op;
  logic          do_pop;
  erc_item_t     in_item;

  assign in_ch.ready = (fill != (PW+1)'(QUEUE_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  assign known_op    = (in_ch.operation == OP_STORE) || (in_ch.operation == OP_LOOKUP) ||
                       (in_ch.operation == OP_LIST);
  assign push        = accept && known_op;
  assign do_pop      = pop && head_valid;

  assign in_item.op         = in_ch.operation;
  assign in_item.now_ms     = in_ch.now_ms;
  assign in_item.peer_id    = in_ch.peer_id;
  assign in_item.rx_stamp   = in_ch.rx_stamp;
  assign in_item.seq_number = in_ch.seq_number;

  assign head       = q[rd_ptr];
  assign head_valid = (fill != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/erc_back.sv =====
// ---------------------------------------------------------------------------
// erc_back
// Peer table and scan sequencer: store, lookup and list, one entry a cycle unless a list result waits on out_ch.
// ---------------------------------------------------------------------------
`default_nettype none

module erc_back #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  erc_pkg::erc_item_t head,
  input  logic               head_valid,
  output logic               pop,
  input  logic [15:0]        validity_period_ms,
  erc_out_if.source          out_ch
);
  import erc_pkg::*;

  localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // table
  logic [7:0]         entry_peer   [TABLE_ENTRIES];
  logic signed [63:0] entry_stamp  [TABLE_ENTRIES];
  logic [7:0]         entry_seq    [TABLE_ENTRIES];
  logic [31:0]        entry_expiry [TABLE_ENTRIES];

  erc_state_t state, state_next;

  logic [IDXW-1:0]    idx;
  logic [IDXW-1:0]    target;
  logic [31:0]        oldest;
  logic [LIMIT_W-1:0] cnt;

  // entry captured for reporting; hold_found doubles as "previous live" on list
  logic               hold_found;
  logic [7:0]         hold_peer;
  logic signed [63:0] hold_stamp;
  logic [7:0]         hold_seq;

  // output register
  logic               o_valid;
  logic               o_found;
  logic [7:0]         o_peer;
  logic signed [63:0] o_stamp;
  logic [7:0]         o_seq;
  logic               o_last;

  logic               is_match;
  logic               is_live;
  logic               at_end;
  logic               out_free;
  logic               list_stop;
  logic               list_emit;
  logic               list_stall;
  logic               out_load;
  logic               out_last_n;
  logic               out_found_n;
  logic               tbl_we;

  assign is_match   = (entry_peer[idx] == head.peer_id);
  assign is_live    = (entry_expiry[idx] > head.now_ms);
  assign at_end     = (idx == IDXW'(TABLE_ENTRIES - 1));
  assign out_free   = !o_valid || out_ch.ready;
  assign list_stop  = (cnt == LIMIT_W'(RESULT_LIMIT));
  assign list_emit  = (state == ST_SCAN) && (head.op == OP_LIST) && !list_stop &&
                      is_live && hold_found;
  assign list_stall = list_emit && !out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (head_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        case (head.op)
          OP_STORE: begin
            if (is_match || at_end) begin
              state_next = ST_WRITE;
            end
          end
          OP_LOOKUP: begin
            if (is_match || at_end) begin
              state_next = ST_FINAL;
            end
          end
          OP_LIST: begin
            if (list_stop || (at_end && !list_stall)) begin
              state_next = ST_FINAL;
            end
          end
          default: state_next = ST_FINAL;
        endcase
      end
      ST_FINAL: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop         = 1'b0;
    out_load    = 1'b0;
    out_last_n  = 1'b0;
    out_found_n = 1'b0;
    tbl_we      = 1'b0;
    case (state)
      ST_SCAN: begin
        out_load    = list_emit && out_free;
        out_found_n = 1'b1;
      end
      ST_FINAL: begin
        pop         = out_free;
        out_load    = out_free;
        out_last_n  = 1'b1;
        out_found_n = hold_found;
      end
      ST_WRITE: begin
        pop    = 1'b1;
        tbl_we = 1'b1;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      target     <= '0;
      oldest     <= EXPIRY_MAX;
      cnt        <= '0;
      hold_found <= 1'b0;
    end else if (state == ST_IDLE) begin
      idx        <= '0;
      target     <= '0;
      oldest     <= EXPIRY_MAX;
      cnt        <= '0;
      hold_found <= 1'b0;
    end else if (state == ST_SCAN && !list_stall) begin
      idx <= idx + 1'b1;
      case (head.op)
        OP_STORE: begin
          if (is_match) begin
            target <= idx;
          end else if (entry_expiry[idx] < oldest) begin
            oldest <= entry_expiry[idx];
            target <= idx;
          end
        end
        OP_LOOKUP: begin
          if (is_match) begin
            hold_found <= is_live;
          end
        end
        OP_LIST: begin
          if (!list_stop && is_live) begin
            hold_found <= 1'b1;
            if (hold_found) begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && !list_stall &&
        ((head.op == OP_LOOKUP && is_match) ||
         (head.op == OP_LIST && !list_stop && is_live))) begin
      hold_peer  <= entry_peer[idx];
      hold_stamp <= entry_stamp[idx];
      hold_seq   <= entry_seq[idx];
    end
  end

  // table storage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        entry_peer[i]   <= '0;
        entry_stamp[i]  <= '0;
        entry_seq[i]    <= '0;
        entry_expiry[i] <= '0;
      end
    end else if (tbl_we) begin
      entry_peer[target]   <= head.peer_id;
      entry_stamp[target]  <= head.rx_stamp;
      entry_seq[target]    <= head.seq_number;
      entry_expiry[target] <= head.now_ms + {16'd0, validity_period_ms};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_found <= out_found_n;
      o_last  <= out_last_n;
      o_peer  <= out_found_n ? hold_peer  : '0;
      o_stamp <= out_found_n ? hold_stamp : '0;
      o_seq   <= out_found_n ? hold_seq   : '0;
    end
  end

  assign out_ch.valid          = o_valid;
  assign out_ch.found          = o_found;
  assign out_ch.out_peer_id    = o_peer;
  assign out_ch.out_rx_stamp   = o_stamp;
  assign out_ch.out_seq_number = o_seq;
  assign out_ch.last           = o_last;

  a_busy_has_item: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> head_valid)
    else $error("sequencer busy without a queued word");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= LIMIT_W'(RESULT_LIMIT))
    else $error("list result count past limit");

  a_final_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL && out_free) |=> (o_valid && o_last && state == ST_IDLE))
    else $error("closing result word not marked last");

  a_list_mid: assert property (@(posedge clk) disable iff (rst)
    (out_load && !out_last_n) |-> (head.op == OP_LIST && hold_found))
    else $error("non-final result outside a list");

endmodule

`default_nettype wire
